### hdl/hwfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwfq_pkg
// Shared types and constants of the two-level fair queueing tag unit.
// ----------------------------------------------------------------------------
package hwfq_pkg;

  localparam int FIDX_W  = 10;
  localparam int REG_W   = 16;
  localparam int PEND_W  = 14;
  localparam int OTAG_W  = 60;
  localparam int PROD_W  = 2 * REG_W;
  localparam int FRAC_W  = 8;

  localparam logic [REG_W-1:0] RT_WGT_RST     = 16'd256;
  localparam logic [REG_W-1:0] LF_WGT_RST     = 16'd256;
  localparam logic [REG_W-1:0] SPLIT_PORT_RST = 16'd4000;

  localparam logic [1:0] CFG_RT_WGT     = 2'd0;
  localparam logic [1:0] CFG_LF_WGT     = 2'd1;
  localparam logic [1:0] CFG_SPLIT_PORT = 2'd2;

  localparam logic OP_ENQ      = 1'b0;
  localparam logic OP_DEQ      = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DROP = 1'b1;
  localparam logic LEAF_LEFT   = 1'b0;
  localparam logic LEAF_RIGHT  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } back_state_t;

  typedef struct packed {
    logic              op;
    logic              bad;
    logic              leaf;
    logic [FIDX_W-1:0] flow_index;
    logic [REG_W-1:0]  packet_length;
    logic [OTAG_W-1:0] leaf_tag;
  } item_t;

  typedef struct packed {
    logic              status;
    logic              leaf_out;
    logic [OTAG_W-1:0] root_tag;
    logic [OTAG_W-1:0] leaf_tag;
  } res_t;

endpackage
`default_nettype wire

### hdl/hwfq_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwfq_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module hwfq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

### hdl/hwfq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwfq_front
// Accepts packet events, checks the flow index and picks the leaf queue of an enqueue.
// ----------------------------------------------------------------------------
module hwfq_front
  import hwfq_pkg::*;
#(
  parameter int FLOWS = 1024
) (
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_op,
  input  wire logic [FIDX_W-1:0] in_flow_index,
  input  wire logic [REG_W-1:0]  in_packet_length,
  input  wire logic [REG_W-1:0]  in_dest_port,
  input  wire logic              in_leaf_in,
  input  wire logic [OTAG_W-1:0] in_leaf_tag_in,
  input  wire logic [REG_W-1:0]  split_port,
  input  wire logic              clearing,
  input  wire logic              q_full,
  output logic                   q_push,
  output item_t                  q_item
);

  localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int CMP_W = IDX_W + FIDX_W;

  logic chosen;

  assign full   = q_full || clearing;
  assign q_push = push && !full;
  assign chosen = (in_dest_port <= split_port) ? LEAF_LEFT : LEAF_RIGHT;

  always_comb begin
    q_item               = '0;
    q_item.op            = in_op;
    q_item.bad           = (CMP_W'(in_flow_index) >= CMP_W'(FLOWS));
    q_item.leaf          = (in_op == OP_ENQ) ? chosen : in_leaf_in;
    q_item.flow_index    = in_flow_index;
    q_item.packet_length = in_packet_length;
    q_item.leaf_tag      = in_leaf_tag_in;
  end

endmodule
`default_nettype wire

### hdl/hwfq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwfq_back
// Flow table read-modify-write, tag arithmetic and virtual time update.
// ----------------------------------------------------------------------------
module hwfq_back
  import hwfq_pkg::*;
#(
  parameter int FLOWS       = 1024,
  parameter int TAG_BITS    = 60,
  parameter int PENDING_MAX = 8192
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [REG_W-1:0] rt_wgt,
  input  wire logic [REG_W-1:0] lf_wgt,
  input  wire item_t            q_item,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output res_t                  res_data,
  output logic                  clearing
);

  localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  typedef struct packed {
    logic                valid;
    logic [PEND_W-1:0]   pending;
    logic [TAG_BITS-1:0] root_fin;
    logic [TAG_BITS-1:0] leaf_fin;
    logic [TAG_BITS-1:0] last_root;
    logic [REG_W-1:0]    rw;
    logic [REG_W-1:0]    lw;
  } flow_ent_t;

  flow_ent_t mem [FLOWS];
  flow_ent_t rd_data_r;
  flow_ent_t ent_r, ent_nxt;
  flow_ent_t wr_data;
  logic      mem_we;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  back_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [TAG_BITS-1:0] root_vt_r, root_vt_nxt;
  logic [TAG_BITS-1:0] left_vt_r, left_vt_nxt;
  logic [TAG_BITS-1:0] right_vt_r, right_vt_nxt;

  item_t               itm_r;
  logic [PROD_W-1:0]   prod_root_r, prod_leaf_r;
  logic [TAG_BITS-1:0] root_start_r, leaf_start_r;
  logic [TAG_BITS-1:0] root_start_nxt, leaf_start_nxt, leaf_vt;
  logic                take, pend_full;
  logic [TAG_BITS-1:0] root_inc, leaf_inc;

  assign clearing = (state_r == S_CLEAR);
  assign take     = (state_r == S_IDLE) && !q_empty && !res_full;
  assign q_pop    = take;
  assign rd_addr  = IDX_W'(q_item.flow_index);

  always_comb begin
    ent_nxt = rd_data_r;
    if (!rd_data_r.valid) begin
      ent_nxt    = '0;
      ent_nxt.rw = rt_wgt;
      ent_nxt.lw = lf_wgt;
    end
    leaf_vt        = (itm_r.leaf == LEAF_LEFT) ? left_vt_r : right_vt_r;
    root_start_nxt = (root_vt_r > ent_nxt.root_fin) ? root_vt_r : ent_nxt.root_fin;
    leaf_start_nxt = (leaf_vt > ent_nxt.leaf_fin) ? leaf_vt : ent_nxt.leaf_fin;
  end

  assign pend_full = ((PEND_W+1)'(ent_r.pending) >= (PEND_W+1)'(PENDING_MAX));
  assign root_inc  = TAG_BITS'(prod_root_r[PROD_W-1:FRAC_W]);
  assign leaf_inc  = TAG_BITS'(prod_leaf_r[PROD_W-1:FRAC_W]);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    root_vt_nxt  = root_vt_r;
    left_vt_nxt  = left_vt_r;
    right_vt_nxt = right_vt_r;
    mem_we       = 1'b0;
    wr_addr      = clr_addr_r;
    wr_data      = '0;
    res_push     = 1'b0;
    res_data     = '0;
    res_data.status = STATUS_DROP;
    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(FLOWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        res_push  = 1'b1;
        wr_addr   = IDX_W'(itm_r.flow_index);
        if (!itm_r.bad && itm_r.op == OP_ENQ && !(ent_r.valid && pend_full)) begin
          mem_we            = 1'b1;
          wr_data           = ent_r;
          wr_data.valid     = 1'b1;
          wr_data.pending   = ent_r.pending + 1'b1;
          wr_data.root_fin  = root_start_r + root_inc;
          wr_data.leaf_fin  = leaf_start_r + leaf_inc;
          wr_data.last_root = root_start_r;
          res_data.status   = STATUS_OK;
          res_data.leaf_out = itm_r.leaf;
          res_data.root_tag = OTAG_W'(root_start_r);
          res_data.leaf_tag = OTAG_W'(leaf_start_r);
        end else if (!itm_r.bad && itm_r.op == OP_DEQ && ent_r.valid) begin
          mem_we = 1'b1;
          if (ent_r.pending > PEND_W'(1)) begin
            wr_data         = ent_r;
            wr_data.pending = ent_r.pending - 1'b1;
          end
          root_vt_nxt = ent_r.last_root;
          if (itm_r.leaf == LEAF_LEFT) begin
            left_vt_nxt = TAG_BITS'(itm_r.leaf_tag);
          end else begin
            right_vt_nxt = TAG_BITS'(itm_r.leaf_tag);
          end
          res_data.status   = STATUS_OK;
          res_data.leaf_out = itm_r.leaf;
          res_data.root_tag = OTAG_W'(ent_r.last_root);
          res_data.leaf_tag = itm_r.leaf_tag;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      root_vt_r  <= '0;
      left_vt_r  <= '0;
      right_vt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      root_vt_r  <= root_vt_nxt;
      left_vt_r  <= left_vt_nxt;
      right_vt_r <= right_vt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      itm_r <= q_item;
    end
    if (state_r == S_READ) begin
      ent_r        <= ent_nxt;
      root_start_r <= root_start_nxt;
      leaf_start_r <= leaf_start_nxt;
      prod_root_r  <= PROD_W'(itm_r.packet_length) * PROD_W'(ent_nxt.rw);
      prod_leaf_r  <= PROD_W'(itm_r.packet_length) * PROD_W'(ent_nxt.lw);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/hierarchical_wfq_tagger_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_wfq_tagger_core
// Two-level start-time fair queueing tag unit with queue-style channels.
// ----------------------------------------------------------------------------
// An accepted transaction passes the item queue and the back end's READ and
//   EXEC states into the output queue. The back end holds one transaction
//   at a time, set by the flow table read-modify-write (read, tag compute,
//   write back). Reset: synchronous; then a clearing pass sweeps the flow
//   table while full stays high. Configuration writes are taken meanwhile.
module hierarchical_wfq_tagger_core
  import hwfq_pkg::*;
#(
  parameter int FLOWS       = 1024,
  parameter int TAG_BITS    = 60,
  parameter int PENDING_MAX = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_op,
  input  wire logic [FIDX_W-1:0] in_flow_index,
  input  wire logic [REG_W-1:0]  in_packet_length,
  input  wire logic [REG_W-1:0]  in_dest_port,
  input  wire logic              in_leaf_in,
  input  wire logic [OTAG_W-1:0] in_leaf_tag_in,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   out_status,
  output logic                   out_leaf_out,
  output logic [OTAG_W-1:0]      out_root_tag,
  output logic [OTAG_W-1:0]      out_leaf_tag
);

  logic [REG_W-1:0] rt_wgt_r, lf_wgt_r, split_port_r;

  logic  q_push, q_full, q_empty, q_pop;
  item_t q_in, q_out;
  logic  res_push, res_full, clearing;
  res_t  res_in, res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_wgt_r     <= RT_WGT_RST;
      lf_wgt_r     <= LF_WGT_RST;
      split_port_r <= SPLIT_PORT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RT_WGT:     rt_wgt_r     <= cfg_data;
        CFG_LF_WGT:     lf_wgt_r     <= cfg_data;
        CFG_SPLIT_PORT: split_port_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hwfq_front #(
    .FLOWS(FLOWS)
  ) u_front (
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_flow_index    (in_flow_index),
    .in_packet_length (in_packet_length),
    .in_dest_port     (in_dest_port),
    .in_leaf_in       (in_leaf_in),
    .in_leaf_tag_in   (in_leaf_tag_in),
    .split_port       (split_port_r),
    .clearing         (clearing),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_in)
  );

  hwfq_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(2)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  hwfq_back #(
    .FLOWS       (FLOWS),
    .TAG_BITS    (TAG_BITS),
    .PENDING_MAX (PENDING_MAX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rt_wgt   (rt_wgt_r),
    .lf_wgt   (lf_wgt_r),
    .q_item   (q_out),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_in),
    .clearing (clearing)
  );

  hwfq_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_status   = res_out.status;
  assign out_leaf_out = res_out.leaf_out;
  assign out_root_tag = res_out.root_tag;
  assign out_leaf_tag = res_out.leaf_tag;

  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result pushed into full output queue");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (empty && !res_push))
    else $error("result produced during flow table clearing");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!q_pop && !res_push))
    else $error("back end took a second transaction too early");

endmodule
`default_nettype wire
